// File: src/fba_pkg.sv
// Shared types and constants of the fit-policy block allocator.
package fba_pkg;

  // Input item modes.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // Fit policies; the fourth code grants nothing.
  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;
  localparam logic [1:0] POLICY_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_FIT_POLICY  = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  localparam int SIZE_W     = 32;
  localparam int BLK_W      = 4;
  localparam int POLICY_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } fba_state_t;

  typedef struct packed {
    logic start;
    logic rd;
    logic commit;
  } fba_cmd_t;

  typedef struct packed {
    logic skip;
    logic last_issue;
    logic out_free;
  } fba_status_t;

endpackage

// File: src/fba_item_if.sv
// Input channel carrying load and request beats.
interface fba_item_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [3:0]  block_index;
  logic [31:0] size;

  modport source (output valid, output mode, output block_index, output size, input ready);
  modport sink   (input valid, input mode, input block_index, input size, output ready);
endinterface

// File: src/fba_result_if.sv
// Output channel carrying allocation result beats.
interface fba_result_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic [3:0]  chosen_block;
  logic [31:0] space_left;

  modport source (output valid, output granted, output chosen_block, output space_left,
                  input ready);
  modport sink   (input valid, input granted, input chosen_block, input space_left,
                  output ready);
endinterface

// File: src/fba_ctrl.sv
// Controller state machine that sequences loads, scans and commits.
module fba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  output fba_pkg::fba_cmd_t cmd,
  input  fba_pkg::fba_status_t status
);
  import fba_pkg::*;

  fba_state_t state;
  fba_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && (in_mode == MODE_REQUEST)) begin
          state_next = status.skip ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.rd     = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid && (in_mode == MODE_REQUEST);
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
      end
      S_DRAIN: begin
        cmd.rd = 1'b0;
      end
      S_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: src/fba_dp.sv
// Datapath: free-space memory, scan pointer, best-candidate tracking and result register.
module fba_dp #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_accept,
  input  logic                          in_mode,
  input  logic [fba_pkg::BLK_W-1:0]     in_block_index,
  input  logic [fba_pkg::SIZE_W-1:0]    in_size,
  input  fba_pkg::fba_cmd_t             cmd,
  output fba_pkg::fba_status_t          status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_granted,
  output logic [fba_pkg::BLK_W-1:0]     out_chosen_block,
  output logic [fba_pkg::SIZE_W-1:0]    out_space_left
);
  import fba_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  logic [SIZE_W-1:0]   mem [NUM_BLOCKS];
  logic [SIZE_W-1:0]   rd_data;
  logic                rd_valid;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    scan_addr;
  logic [SIZE_W-1:0]   req_size;
  logic [SIZE_W-1:0]   best_val;
  logic [IDX_W-1:0]    best_idx;
  logic                found;
  logic [POLICY_W-1:0] fit_policy;
  logic [COUNT_W-1:0]  block_count;
  logic [CNT_W-1:0]    count_eff;
  logic                better;
  logic                take;
  logic                wen;
  logic [IDX_W-1:0]    waddr;
  logic [SIZE_W-1:0]   wdata;
  logic [SIZE_W-1:0]   remain;

  // Block count saturates at the table depth.
  always_comb begin
    if (32'(block_count) > NUM_BLOCKS) begin
      count_eff = CNT_W'(NUM_BLOCKS);
    end else begin
      count_eff = CNT_W'(block_count);
    end
  end

  assign status.skip       = (count_eff == '0) || (fit_policy == POLICY_NONE);
  assign status.last_issue = ((CNT_W'(scan_addr) + CNT_W'(1)) == count_eff);
  assign status.out_free   = !out_valid || out_ready;

  always_comb begin
    case (fit_policy)
      POLICY_BEST:  better = rd_data < best_val;
      POLICY_WORST: better = rd_data > best_val;
      default:      better = 1'b0;
    endcase
  end

  assign take   = rd_valid && (rd_data >= req_size) && (!found || better);
  assign remain = best_val - req_size;

  // Single write port shared by loads and the commit update; they never coincide.
  always_comb begin
    wen   = 1'b0;
    waddr = best_idx;
    wdata = remain;
    if (in_accept && (in_mode == MODE_LOAD) && (32'(in_block_index) < NUM_BLOCKS)) begin
      wen   = 1'b1;
      waddr = IDX_W'(in_block_index);
      wdata = in_size;
    end else if (cmd.commit && found) begin
      wen = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rd_data <= mem[scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= POLICY_FIRST;
      block_count <= '0;
      rd_valid    <= 1'b0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIT_POLICY:  fit_policy  <= cfg_data[POLICY_W-1:0];
          CFG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
          default:         fit_policy  <= fit_policy;
        endcase
      end
      rd_valid <= cmd.rd;
      if (cmd.start || cmd.commit) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_size  <= in_size;
      scan_addr <= '0;
    end else if (cmd.rd) begin
      scan_addr <= scan_addr + IDX_W'(1);
    end
    if (cmd.rd) begin
      rd_idx <= scan_addr;
    end
    if (take) begin
      best_val <= rd_data;
      best_idx <= rd_idx;
    end
    if (cmd.commit) begin
      out_granted      <= found;
      out_chosen_block <= found ? BLK_W'(best_idx) : '0;
      out_space_left   <= found ? remain : '0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

  a_refused_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_granted) |-> ((out_chosen_block == '0) && (out_space_left == '0)))
    else $error("refused result carries nonzero fields");

  a_start_idle_pipe: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (!rd_valid && !found))
    else $error("request started while a scan was still in flight");

endmodule

// File: src/fit_policy_block_allocator_core.sv
// Top level of the fit-policy block allocator.
//
// This block keeps the free space of up to NUM_BLOCKS memory blocks in a
// single-port-write, single-port-read memory. A load beat (mode 0) writes the
// size of one block in the cycle it is accepted and gives no result; loads to
// an index at or beyond NUM_BLOCKS are dropped. A request beat (mode 1) scans
// blocks 0 to block_count-1 (block_count saturates at NUM_BLOCKS) one entry per
// cycle through the memory read port, keeping the best fitting block under the
// first, best or worst fit policy, with ties going to the lower index. The
// request is then subtracted from the chosen block and one result beat reports
// it; if nothing fits, or the policy code is the unused fourth one, the result
// is not granted with zero block and space fields. A request occupies the
// block from acceptance to the result being loaded in these steps: acceptance,
// one read issue per block, a drain step for the last registered read, and
// one commit; with nothing to scan it goes from acceptance straight to commit.
// The scan uses the single read port. The result sits in an output register, so
// a new beat is taken as soon as the commit is done, even before the result is
// taken; a request that finishes while the previous result still waits holds
// in its commit step. Blocks must be loaded before a request reads them.
// The configuration port is not gated by the core, so registers must be
// written only while the block is idle with no request in flight.
module fit_policy_block_allocator_core #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_data,
  fba_item_if.sink                       item,
  fba_result_if.source                   result
);
  import fba_pkg::*;

  fba_cmd_t    cmd;
  fba_status_t status;
  logic        in_accept;

  // A beat on the input channel is taken when both sides agree.
  assign in_accept = item.valid && item.ready;

  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_mode  (item.mode),
    .in_ready (item.ready),
    .cmd      (cmd),
    .status   (status)
  );

  fba_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_accept        (in_accept),
    .in_mode          (item.mode),
    .in_block_index   (item.block_index),
    .in_size          (item.size),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_granted      (result.granted),
    .out_chosen_block (result.chosen_block),
    .out_space_left   (result.space_left)
  );

endmodule
